[design/qse_pkg.sv]
// qse_pkg: shared constants for the quicksort engine
`timescale 1ns / 1ps
`default_nettype none
package qse_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int KEY_WIDTH_DEF = 32;

endpackage
`default_nettype wire

[design/qse_in_if.sv]
// qse_in_if: key load channel of the quicksort engine
`timescale 1ns / 1ps
`default_nettype none
interface qse_in_if #(
  parameter int KEY_WIDTH = qse_pkg::KEY_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] key_in;
  logic                        last_in;

  modport source (output valid, output key_in, output last_in, input ready);
  modport sink (input valid, input key_in, input last_in, output ready);
endinterface
`default_nettype wire

[design/qse_out_if.sv]
// qse_out_if: sorted key channel of the quicksort engine
`timescale 1ns / 1ps
`default_nettype none
interface qse_out_if #(
  parameter int KEY_WIDTH = qse_pkg::KEY_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] key_out;
  logic                        last_out;
  logic                        overflowed;

  modport source (output valid, output key_out, output last_out, output overflowed, input ready);
  modport sink (input valid, input key_out, input last_out, input overflowed, output ready);
endinterface
`default_nettype wire

[design/quicksort_engine.sv]
// Keys arrive one per request on in_ch and are stored until the request marked last; keys beyond
// MAX_ITEMS are dropped and every result of that run then carries overflowed. The stored set is
// sorted in place (quicksort, last element of each range as pivot, ranges kept on an explicit
// stack memory) and streamed out on out_ch, last_out on the final key. cfg_wdata set to 1 sorts
// descending; write it only while the engine is idle. Loading accepts one key per cycle. In a
// partition each element is read from the key store, compared with the pivot and, when it
// goes left, swapped with two writes through the single write port; the scan waits on the
// registered read of the key store. Each range is popped from the stack, its pivot read and
// scanned; the pivot is then written into place and sub-ranges of two or more keys pushed.
// Each sorted key is read from the store and held on out_ch until it is taken. No new key is
// taken while a run is sorting or emitting.
`timescale 1ns / 1ps
`default_nettype none
module quicksort_engine #(
  parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEF,
  parameter int KEY_WIDTH = qse_pkg::KEY_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qse_in_if.sink    in_ch,
  qse_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int SD  = MAX_ITEMS / 2;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int SPW = $clog2(SD + 1);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_POP,
    S_POP_W,
    S_PIVOT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_SWAP,
    S_FIN_RD,
    S_FIN_W1,
    S_FIN_W2,
    S_PUSH_R,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
  } range_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [AW-1:0]         lo_r, lo_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [AW-1:0]         i_r, i_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         e_r, e_nxt;
  logic [KEY_WIDTH-1:0]  pivot_r, pivot_nxt;
  logic [KEY_WIDTH-1:0]  tmp_r, tmp_nxt;
  logic                  order_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_WIDTH-1:0]  out_key_r, out_key_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // key store: one write port, two registered read ports
  logic [KEY_WIDTH-1:0]  key_mem [MAX_ITEMS];
  logic                  km_we;
  logic [AW-1:0]         km_waddr;
  logic [KEY_WIDTH-1:0]  km_wdata;
  logic [AW-1:0]         km_ra, km_rb;
  logic [KEY_WIDTH-1:0]  km_rda_r, km_rdb_r;

  // range stack
  range_t                stk_mem [SD];
  logic                  sk_we;
  logic [SAW-1:0]        sk_waddr;
  range_t                sk_wdata;
  logic [SAW-1:0]        sk_raddr;
  range_t                sk_rdata_r;

  logic                  in_acc;
  logic                  goes_left;
  logic                  scan_done;
  logic [AW:0]           lo_plus1, pos_plus1;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign goes_left = order_r ? ($signed(km_rda_r) >= $signed(pivot_r))
                             : ($signed(km_rda_r) <= $signed(pivot_r));
  assign scan_done = ((i_r + AW'(1)) == hi_r);
  assign lo_plus1  = {1'b0, lo_r} + (AW+1)'(1);
  assign pos_plus1 = {1'b0, pos_r} + (AW+1)'(1);

  assign in_ch.ready       = (state_r == S_LOAD);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_out    = out_key_r;
  assign out_ch.last_out   = out_last_r;
  assign out_ch.overflowed = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    e_nxt         = e_r;
    pivot_nxt     = pivot_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    km_we         = 1'b0;
    km_waddr      = pos_r;
    km_wdata      = km_rda_r;
    km_ra         = i_r;
    km_rb         = pos_r;
    sk_we         = 1'b0;
    sk_waddr      = sp_r[SAW-1:0];
    sk_wdata      = '{lo: lo_r, hi: hi_r};
    sk_raddr      = SAW'(sp_r - SPW'(1));

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_ITEMS)) begin
            km_we     = 1'b1;
            km_waddr  = count_r[AW-1:0];
            km_wdata  = in_ch.key_in;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_in) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (count_r < CW'(2)) begin
          e_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          sk_we     = 1'b1;
          sk_waddr  = '0;
          sk_wdata  = '{lo: '0, hi: AW'(count_r - CW'(1))};
          sp_nxt    = SPW'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          e_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          sp_nxt    = sp_r - SPW'(1);
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        lo_nxt    = sk_rdata_r.lo;
        hi_nxt    = sk_rdata_r.hi;
        i_nxt     = sk_rdata_r.lo;
        pos_nxt   = sk_rdata_r.lo;
        km_ra     = sk_rdata_r.hi;
        state_nxt = S_PIVOT;
      end
      S_PIVOT: begin
        pivot_nxt = km_rda_r;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (goes_left) begin
          // first half of the swap: element i moves to pos
          km_we     = 1'b1;
          km_waddr  = pos_r;
          km_wdata  = km_rda_r;
          tmp_nxt   = km_rdb_r;
          state_nxt = S_SCAN_SWAP;
        end else if (scan_done) begin
          state_nxt = S_FIN_RD;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_SWAP: begin
        km_we    = 1'b1;
        km_waddr = i_r;
        km_wdata = tmp_r;
        pos_nxt  = pos_r + AW'(1);
        if (scan_done) begin
          state_nxt = S_FIN_RD;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_W1;
      end
      S_FIN_W1: begin
        km_we     = 1'b1;
        km_waddr  = hi_r;
        km_wdata  = km_rdb_r;
        state_nxt = S_FIN_W2;
      end
      S_FIN_W2: begin
        km_we    = 1'b1;
        km_waddr = pos_r;
        km_wdata = pivot_r;
        if ({1'b0, pos_r} > lo_plus1) begin
          sk_we    = 1'b1;
          sk_wdata = '{lo: lo_r, hi: pos_r - AW'(1)};
          sp_nxt   = sp_r + SPW'(1);
        end
        state_nxt = S_PUSH_R;
      end
      S_PUSH_R: begin
        if (pos_plus1 < {1'b0, hi_r}) begin
          sk_we    = 1'b1;
          sk_wdata = '{lo: pos_r + AW'(1), hi: hi_r};
          sp_nxt   = sp_r + SPW'(1);
        end
        state_nxt = S_POP;
      end
      S_EMIT_RD: begin
        km_ra     = e_r;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = km_rda_r;
        out_last_nxt  = (CW'(e_r) == (count_r - CW'(1)));
        out_ovf_nxt   = ovf_r;
        state_nxt     = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        // prefetch the next key so that S_EMIT_LD can load it as soon as the request is taken
        km_ra = e_r + AW'(1);
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            sp_nxt    = '0;
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + AW'(1);
            state_nxt = S_EMIT_LD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    i_r       <= i_nxt;
    pos_r     <= pos_nxt;
    e_r       <= e_nxt;
    pivot_r   <= pivot_nxt;
    tmp_r     <= tmp_nxt;
    out_key_r <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (km_we) begin
      key_mem[km_waddr] <= km_wdata;
    end
    km_rda_r <= key_mem[km_ra];
    km_rdb_r <= key_mem[km_rb];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      stk_mem[sk_waddr] <= sk_wdata;
    end
    sk_rdata_r <= stk_mem[sk_raddr];
  end

  a_out_only_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT_HOLD))
    else $error("result shown outside the emit hold state");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(SD))
    else $error("range stack overrun");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CMP || state_r == S_SCAN_SWAP)
      |-> (lo_r <= pos_r && pos_r <= i_r && i_r < hi_r))
    else $error("partition indices out of order");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_out)
      |=> (count_r == '0 && !ovf_r && state_r == S_LOAD))
    else $error("run state not cleared after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("key count beyond store depth");

endmodule
`default_nettype wire

[verif/testbench.sv]
// testbench: self-checking bench for the quicksort engine, load, sort order and overflow
`timescale 1ns / 1ps
module testbench;

  localparam int KW          = qse_pkg::KEY_WIDTH_DEF;
  localparam int STORE_DEPTH = qse_pkg::MAX_ITEMS_DEF;
  localparam int ITEM_TARGET = 350;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [KW-1:0] key_t;

  localparam key_t KEY_MIN = key_t'({1'b1, {(KW-1){1'b0}}});
  localparam key_t KEY_MAX = key_t'({1'b0, {(KW-1){1'b1}}});

  typedef enum logic [1:0] {ROW_KEY, ROW_ORDER} row_kind_t;
  typedef enum logic {ORDER_ASC = 1'b0, ORDER_DESC = 1'b1} order_t;

  typedef struct {
    row_kind_t kind;
    order_t    order;
    key_t      key;
    bit        last;
    bit        typed;
    key_t      want;
  } stim_row_t;

  typedef struct {
    key_t key;
    bit   last;
    bit   ovf;
  } sorted_key_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  qse_in_if  in_ch ();
  qse_out_if out_ch ();

  quicksort_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  key_t        pending_keys[$];
  bit          keys_dropped;
  order_t      sort_order;
  sorted_key_t sorted_due[$];

  int mismatches;
  int cycle_count;
  int items_sent;
  bit calm;
  bit hold_armed;

  stim_row_t directed_rows [0:23] = '{
    '{ROW_ORDER, ORDER_ASC,  key_t'(0),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(0),  1'b1, 1'b1, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  KEY_MIN,    1'b1, 1'b1, KEY_MIN},
    '{ROW_KEY,   ORDER_ASC,  KEY_MAX,    1'b1, 1'b1, KEY_MAX},
    '{ROW_KEY,   ORDER_ASC,  key_t'(-1), 1'b1, 1'b1, key_t'(-1)},
    '{ROW_KEY,   ORDER_ASC,  KEY_MAX,    1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  KEY_MIN,    1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(0),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(-1), 1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(1),  1'b1, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(7),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(7),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(7),  1'b1, 1'b0, key_t'(0)},
    '{ROW_ORDER, ORDER_DESC, key_t'(0),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(3),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  KEY_MIN,    1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  KEY_MAX,    1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(3),  1'b1, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(1),  1'b1, 1'b1, key_t'(1)},
    '{ROW_ORDER, ORDER_ASC,  key_t'(0),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(4),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(3),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(2),  1'b0, 1'b0, key_t'(0)},
    '{ROW_KEY,   ORDER_ASC,  key_t'(1),  1'b1, 1'b0, key_t'(0)}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // stores one accepted key; on the last key sorts the set and queues its results
  task automatic load_key(key_t k, bit lst, bit typed, key_t want);
    key_t hold;
    int   j;
    int   n;
    if (pending_keys.size() < STORE_DEPTH) begin
      pending_keys.push_back(k);
    end else begin
      keys_dropped = 1'b1;
    end
    if (lst) begin
      n = pending_keys.size();
      for (int i = 1; i < n; i++) begin
        hold = pending_keys[i];
        j = i;
        while (j > 0 && ((sort_order == ORDER_DESC) ? (pending_keys[j-1] < hold)
                                                    : (pending_keys[j-1] > hold))) begin
          pending_keys[j] = pending_keys[j-1];
          j--;
        end
        pending_keys[j] = hold;
      end
      if (typed) begin
        sorted_due.push_back('{want, 1'b1, 1'b0});
      end else begin
        for (int i = 0; i < n; i++) begin
          sorted_due.push_back('{pending_keys[i], i == n - 1, keys_dropped});
        end
      end
      pending_keys.delete();
      keys_dropped = 1'b0;
    end
  endtask

  task automatic offer_key(key_t k, bit lst, bit typed, key_t want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.key_in  <= k;
    in_ch.last_in <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    load_key(k, lst, typed, want);
    items_sent++;
  endtask

  // order is only changed with no run in flight
  task automatic set_order(order_t ord);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ord;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sort_order = ord;
  endtask

  task automatic send_set(int n);
    key_t base;
    key_t k;
    int   style;
    base  = key_t'($urandom);
    style = $urandom_range(9);
    for (int i = 0; i < n; i++) begin
      case (style)
        5, 6: begin
          k = key_t'(int'($urandom_range(7)) - 4);
        end
        7: begin
          k = base + key_t'(i);
        end
        8: begin
          k = base - key_t'(i);
        end
        9: begin
          k = base;
        end
        default: begin
          k = key_t'($urandom);
        end
      endcase
      calm = (items_sent >= 150 && items_sent < 230);
      offer_key(k, i == n - 1, 1'b0, key_t'(0));
    end
  endtask

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 72) begin
      return $urandom_range(12, 1);
    end else if (r < 88) begin
      return $urandom_range(40, 13);
    end else if (r < 94) begin
      return STORE_DEPTH;
    end
    return $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
  endfunction

  initial begin : main_flow
    int n_sets;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.key_in  = '0;
    in_ch.last_in = 1'b0;
    sort_order    = ORDER_ASC;
    keys_dropped  = 1'b0;
    calm          = 1'b0;
    hold_armed    = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_ORDER) begin
        set_order(directed_rows[r].order);
      end else begin
        offer_key(directed_rows[r].key, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // a full store plus dropped keys, with the long output hold-off on its results
    set_order(ORDER_ASC);
    hold_armed = 1'b1;
    send_set(STORE_DEPTH + 2);
    send_set($urandom_range(12, 2));

    while (items_sent < ITEM_TARGET) begin
      set_order(order_t'($urandom_range(1)));
      n_sets = $urandom_range(4, 1);
      for (int s = 0; s < n_sets && items_sent < ITEM_TARGET; s++) begin
        send_set(pick_set_size());
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("[quicksort_engine] OK");
    end else begin
      $display("[quicksort_engine] ERROR");
    end
    $finish;
  end

  initial begin : drive_ready
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done && out_ch.valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin : check_results
    sorted_key_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_due.size() == 0) begin
        report_mismatch("unexpected key_out", longint'(out_ch.key_out), 0);
      end else begin
        due = sorted_due.pop_front();
        if (out_ch.key_out !== due.key) begin
          report_mismatch("key_out", longint'(out_ch.key_out), longint'(due.key));
        end
        if (out_ch.last_out !== due.last) begin
          report_mismatch("last_out", longint'(out_ch.last_out), longint'(due.last));
        end
        if (out_ch.overflowed !== due.ovf) begin
          report_mismatch("overflowed", longint'(out_ch.overflowed), longint'(due.ovf));
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[quicksort_engine] ERROR");
    $finish;
  end

endmodule
